/* src/trl_pkg.sv */
// ----------------------------------------------------------------------------
// trl_pkg
// Shared types and constants of the timestamped reading ring log: field
// widths, command codes, controller states and the divider handshake.
// ----------------------------------------------------------------------------
package trl_pkg;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int TIME_W     = 32;
    localparam int DELTA_W    = 16;
    localparam int OFFSET_W   = 8;
    localparam int COUNT_W    = 9;
    localparam int INTERVAL_W = 16;
    localparam int RECORD_W   = VALUE_W + DELTA_W;

    // Default log depth
    localparam int DEPTH_DEF = 256;

    // Divider widths: dividend is 2*elapsed + interval, divisor is 2*interval
    localparam int DIVD_W = TIME_W + 2;
    localparam int DIVS_W = INTERVAL_W + 1;
    localparam int STEP_W = $clog2(DIVD_W);

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_RD_ADDR,
        ST_RD_DATA
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DELTA_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* src/trl_ram.sv */
// ----------------------------------------------------------------------------
// trl_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module trl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/trl_div.sv */
// ----------------------------------------------------------------------------
// trl_div
// Bit-serial restoring divider for the rounded time delta. One quotient bit
// per cycle; the quotient is saturated to the delta width.
// ----------------------------------------------------------------------------
module trl_div
    import trl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_div;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;
    logic [DIVS_W-1:0] n_rem;

    // Trial subtract of the next dividend bit
    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end

    // Control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    // Saturate the quotient
    assign o_rsp = '{
        done:     r_done,
        quotient: (|r_quo[DIVD_W-1:DELTA_W]) ? {DELTA_W{1'b1}} : r_quo[DELTA_W-1:0]
    };

endmodule

/* src/timestamped_reading_ring_log.sv */
// From the accepting edge to the edge that raises o_done: an add with a computed delta
// runs the 34 divider steps, captures the quotient and writes; a first record or time
// running backwards only writes; a read hit reads the RAM; a read miss answers at once.
// One item at a time: busy drops as the strobe rises, so the next item is taken no
// sooner than the strobe cycle; the receiver cannot stall. Synchronous active-low
// reset clears pointer, count and last add time, sets the interval to 1; memory is kept.
// ----------------------------------------------------------------------------
// timestamped_reading_ring_log
// Ring log of sensor readings with quantized time deltas. Records live in one
// RAM; a sequencer adds, overwriting the oldest when full, or reads by offset.
// ----------------------------------------------------------------------------
module timestamped_reading_ring_log
    import trl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [VALUE_W-1:0]    i_reading_value,
    input  logic [TIME_W-1:0]     i_now_seconds,
    input  logic [OFFSET_W-1:0]   i_read_offset,
    output logic                  o_done,
    output logic [VALUE_W-1:0]    o_record_value,
    output logic [DELTA_W-1:0]    o_record_delta,
    output logic                  o_record_valid,
    output logic [COUNT_W-1:0]    o_stored_count,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [INTERVAL_W-1:0] i_cfg_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (PW + 1 > OFFSET_W) ? PW + 1 : OFFSET_W;

    t_state                r_state, n_state;
    logic [PW-1:0]         r_wp, n_wp;
    logic [CW-1:0]         r_count, n_count;
    logic [TIME_W-1:0]     r_last, n_last;
    logic [INTERVAL_W-1:0] r_interval;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic [OFFSET_W-1:0]   r_offset, n_offset;
    logic [DELTA_W-1:0]    r_delta, n_delta;
    logic                  r_o_done, n_o_done;
    logic                  r_o_valid, n_o_valid;
    logic [VALUE_W-1:0]    r_o_value, n_o_value;
    logic [DELTA_W-1:0]    r_o_delta, n_o_delta;
    logic [COUNT_W-1:0]    r_o_count, n_o_count;

    t_div_req              div_req;
    t_div_rsp              div_rsp;
    logic                  div_start;
    logic                  ram_we;
    logic [PW-1:0]         ram_raddr;
    logic [RECORD_W-1:0]   ram_rdata;

    logic [INTERVAL_W-1:0] iv;
    logic [TIME_W-1:0]     elapsed;
    logic                  hit;
    logic                  full;
    logic [SW-1:0]         slot_sum;
    logic [SW-1:0]         slot_wrap;
    logic [PW-1:0]         wp_inc;
    logic [CW-1:0]         count_inc;

    // Record store
    trl_ram #(
        .WIDTH (RECORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata ({r_value, r_delta}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Delta divider
    trl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Treat a zero interval as one; form rounded division operands
    always_comb begin
        iv      = (r_interval == '0) ? INTERVAL_W'(1) : r_interval;
        elapsed = i_now_seconds - r_last;
        div_req.start    = div_start;
        div_req.dividend = {1'b0, elapsed, 1'b0} + DIVD_W'(iv);
        div_req.divisor  = {iv, 1'b0};
    end

    // Pointer and count advance, read slot from the oldest record
    always_comb begin
        full      = (r_count == CW'(DEPTH));
        wp_inc    = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        count_inc = full ? r_count : r_count + 1'b1;
        hit       = (SW'(i_read_offset) < SW'(r_count));
        slot_sum  = (full ? SW'(r_wp) : '0) + SW'(r_offset);
        slot_wrap = (slot_sum >= SW'(DEPTH)) ? slot_sum - SW'(DEPTH) : slot_sum;
        ram_raddr = slot_wrap[PW-1:0];
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_count   = r_count;
        n_last    = r_last;
        n_value   = r_value;
        n_offset  = r_offset;
        n_delta   = r_delta;
        n_o_done  = 1'b0;
        n_o_valid = 1'b0;
        n_o_value = r_o_value;
        n_o_delta = r_o_delta;
        n_o_count = r_o_count;
        div_start = 1'b0;
        ram_we    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_value  = i_reading_value;
                    n_offset = i_read_offset;
                    if (i_command == CMD_ADD) begin
                        n_last = i_now_seconds;
                        if (r_count == '0 || i_now_seconds < r_last) begin
                            n_delta = '0;
                            n_state = ST_WRITE;
                        end else begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                    end else if (hit) begin
                        n_state = ST_RD_ADDR;
                    end else begin
                        n_o_done  = 1'b1;
                        n_o_value = '0;
                        n_o_delta = '0;
                        n_o_count = COUNT_W'(r_count);
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_delta = div_rsp.quotient;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ram_we    = 1'b1;
                n_wp      = wp_inc;
                n_count   = count_inc;
                n_o_done  = 1'b1;
                n_o_value = '0;
                n_o_delta = r_delta;
                n_o_count = COUNT_W'(count_inc);
                n_state   = ST_IDLE;
            end
            ST_RD_ADDR: begin
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                n_o_done  = 1'b1;
                n_o_valid = 1'b1;
                n_o_value = ram_rdata[RECORD_W-1:DELTA_W];
                n_o_delta = ram_rdata[DELTA_W-1:0];
                n_o_count = COUNT_W'(r_count);
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wp       <= '0;
            r_count    <= '0;
            r_last     <= '0;
            r_interval <= INTERVAL_W'(1);
            r_o_done   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_count   <= n_count;
            r_last    <= n_last;
            r_o_done  <= n_o_done;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_interval <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_offset  <= n_offset;
        r_delta   <= n_delta;
        r_o_value <= n_o_value;
        r_o_delta <= n_o_delta;
        r_o_count <= n_o_count;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = (r_state == ST_IDLE);
    assign o_done         = r_o_done;
    assign o_record_value = r_o_value;
    assign o_record_delta = r_o_delta;
    assign o_record_valid = r_o_valid;
    assign o_stored_count = r_o_count;

endmodule

/* src/trl_checker.sv */
// ----------------------------------------------------------------------------
// trl_checker
// Port-level checks of the ring log: reset, sequencing of an add, result
// strobe qualification and the configuration interlock.
// ----------------------------------------------------------------------------
module trl_checker
    import trl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  i_command,
    input logic                  o_done,
    input logic [VALUE_W-1:0]    o_record_value,
    input logic                  o_record_valid,
    input logic [COUNT_W-1:0]    o_stored_count,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready
);

    // Reset leaves the block idle with no result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done)
        else $error("block not idle after reset");

    // An accepted add keeps the block busy in the next cycle
    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_command == CMD_ADD |=> busy)
        else $error("add accepted but block not busy");

    // A valid record is only flagged together with the strobe
    a_valid_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_record_valid |-> o_done)
        else $error("record valid without result strobe");

    // Results without a record carry a zero value and a bounded count
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_record_valid |-> o_record_value == '0
            && 32'(o_stored_count) <= DEPTH)
        else $error("result without record carries data");

    // Configuration is held off only while an item is in work
    a_cfg_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && !o_cfg_ready |-> busy)
        else $error("configuration stalled while idle");

endmodule

bind timestamped_reading_ring_log trl_checker #(.DEPTH(DEPTH)) u_trl_checker (.*);

/* tb/trl_log_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trl_log_checker
// Watches the item, result and register channels of the ring log, keeps its
// own copy of the log state, and compares every result strobe in order
// against the predicted record. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module trl_log_checker
    import trl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_command,
    input  logic [VALUE_W-1:0]    i_reading_value,
    input  logic [TIME_W-1:0]     i_now_seconds,
    input  logic [OFFSET_W-1:0]   i_read_offset,
    input  logic                  i_done,
    input  logic [VALUE_W-1:0]    i_record_value,
    input  logic [DELTA_W-1:0]    i_record_delta,
    input  logic                  i_record_valid,
    input  logic [COUNT_W-1:0]    i_stored_count,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [INTERVAL_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int PTR_W = $clog2(DEPTH_DEF);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [DELTA_W-1:0] delta;
        logic               valid;
        logic [COUNT_W-1:0] count;
    } t_log_result;

    // Mirror of the log contents and registers
    logic [VALUE_W-1:0]    ring_value [DEPTH_DEF];
    logic [DELTA_W-1:0]    ring_delta [DEPTH_DEF];
    logic [PTR_W-1:0]      ring_wr_ptr;
    int                    ring_count;
    logic [TIME_W-1:0]     last_add_time;
    logic [INTERVAL_W-1:0] cfg_interval;

    t_log_result expected_records[$];
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    // Apply one item to the mirror and return the record it should produce
    function automatic t_log_result log_apply(
        input logic                cmd,
        input logic [VALUE_W-1:0]  value,
        input logic [TIME_W-1:0]   now,
        input logic [OFFSET_W-1:0] offset
    );
        t_log_result      res;
        logic [63:0]      elapsed;
        logic [63:0]      span;
        logic [63:0]      quot;
        logic [PTR_W-1:0] slot;
        res = '0;
        if (cmd == CMD_ADD) begin
            // First record and time running backwards both store a zero delta
            if (ring_count != 0 && now >= last_add_time) begin
                elapsed   = 64'(now - last_add_time);
                span      = (cfg_interval == '0) ? 64'd1 : 64'(cfg_interval);
                // round half up: floor((2*elapsed + interval) / (2*interval))
                quot      = (64'd2 * elapsed + span) / (64'd2 * span);
                res.delta = (quot > 64'hFFFF) ? 16'hFFFF : quot[DELTA_W-1:0];
            end
            ring_value[ring_wr_ptr] = value;
            ring_delta[ring_wr_ptr] = res.delta;
            ring_wr_ptr             = PTR_W'((int'(ring_wr_ptr) + 1) % DEPTH_DEF);
            last_add_time           = now;
            if (ring_count < DEPTH_DEF) ring_count++;
        end else if (int'(offset) < ring_count) begin
            // offset counts from the oldest held record
            slot      = PTR_W'((int'(ring_wr_ptr) + DEPTH_DEF - ring_count
                               + int'(offset)) % DEPTH_DEF);
            res.value = ring_value[slot];
            res.delta = ring_delta[slot];
            res.valid = 1'b1;
        end
        res.count = COUNT_W'(ring_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Compare results first, then take a new item accepted at the same edge
    always @(posedge i_clk) begin : log_monitor
        t_log_result want;
        if (!i_rst_n) begin
            ring_wr_ptr   = '0;
            ring_count    = 0;
            last_add_time = '0;
            cfg_interval  = 16'd1;
            expected_records.delete();
        end else begin
            if (i_done) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("unrequested result value", i_record_value, 0);
                end else begin
                    want = expected_records.pop_front();
                    if (i_record_value !== want.value)
                        report_mismatch("record_value", i_record_value, want.value);
                    if (i_record_delta !== want.delta)
                        report_mismatch("record_delta", 32'(i_record_delta),
                                        32'(want.delta));
                    if (i_record_valid !== want.valid)
                        report_mismatch("record_valid", 32'(i_record_valid),
                                        32'(want.valid));
                    if (i_stored_count !== want.count)
                        report_mismatch("stored_count", 32'(i_stored_count),
                                        32'(want.count));
                end
            end
            if (i_start && !i_busy) begin
                expected_records.push_back(log_apply(i_command, i_reading_value,
                                                     i_now_seconds, i_read_offset));
            end
            if (i_cfg_valid && i_cfg_ready) cfg_interval = i_cfg_data;
        end
        o_pending <= expected_records.size();
    end

endmodule

/* tb/tb_timestamped_reading_ring_log.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamped_reading_ring_log
// Drives add and read items into the ring log under several interval
// settings, with random sender gaps, while a checker predicts every record.
// Covers empty reads, rounding edges, backwards time, saturation and wrap.
// ----------------------------------------------------------------------------
module tb_timestamped_reading_ring_log;
    import trl_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 88;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_command;
    logic [VALUE_W-1:0]    i_reading_value;
    logic [TIME_W-1:0]     i_now_seconds;
    logic [OFFSET_W-1:0]   i_read_offset;
    logic                  o_done;
    logic [VALUE_W-1:0]    o_record_value;
    logic [DELTA_W-1:0]    o_record_delta;
    logic                  o_record_valid;
    logic [COUNT_W-1:0]    o_stored_count;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [INTERVAL_W-1:0] i_cfg_data;

    int                    pending;
    int                    fail_count;
    int                    idle_cycles = 0;

    // Stimulus-side view of the log, used only to shape the items
    logic [TIME_W-1:0]     stim_last_time = '0;
    int                    stim_count     = 0;
    logic [INTERVAL_W-1:0] stim_interval  = 16'd1;
    bit                    quiet_stretch  = 1'b0;

    timestamped_reading_ring_log dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_reading_value (i_reading_value),
        .i_now_seconds   (i_now_seconds),
        .i_read_offset   (i_read_offset),
        .o_done          (o_done),
        .o_record_value  (o_record_value),
        .o_record_delta  (o_record_delta),
        .o_record_valid  (o_record_valid),
        .o_stored_count  (o_stored_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    trl_log_checker u_log_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_command       (i_command),
        .i_reading_value (i_reading_value),
        .i_now_seconds   (i_now_seconds),
        .i_read_offset   (i_read_offset),
        .i_done          (o_done),
        .i_record_value  (o_record_value),
        .i_record_delta  (o_record_delta),
        .i_record_valid  (o_record_valid),
        .i_stored_count  (o_stored_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drop start and hold until every result has come back
    task automatic wait_log_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || pending != 0);
    endtask

    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        wait_log_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        stim_interval  = value;
    endtask

    // Present one item after a random gap and hold it until taken
    task automatic issue_entry(input logic cmd, input logic [VALUE_W-1:0] value,
                               input logic [TIME_W-1:0] now,
                               input logic [OFFSET_W-1:0] offset);
        int unsigned gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_reading_value <= value;
        i_now_seconds   <= now;
        i_read_offset   <= offset;
        do @(posedge i_clk); while (busy);
        if (cmd == CMD_ADD) begin
            stim_last_time = now;
            if (stim_count < DEPTH_DEF) stim_count++;
        end
    endtask

    // Mostly plausible time steps, with backwards, equal and far jumps mixed in
    task automatic issue_random();
        logic [TIME_W-1:0]   now;
        logic [OFFSET_W-1:0] off;
        int unsigned         pick;
        int unsigned         iv;
        iv = (stim_interval == '0) ? 1 : stim_interval;
        if ($urandom_range(0, 99) < 55) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      now = stim_last_time + $urandom_range(0, 4 * iv + 2);
            else if (pick < 75) now = stim_last_time + $urandom_range(0, 3) * iv + iv / 2;
            else if (pick < 85) now = stim_last_time - $urandom_range(1, 2 * iv);
            else if (pick < 92) now = stim_last_time;
            else                now = $urandom;
            issue_entry(CMD_ADD, $urandom, now, OFFSET_W'($urandom));
        end else begin
            if (stim_count > 0 && $urandom_range(0, 4) != 0)
                off = OFFSET_W'($urandom_range(0, stim_count - 1));
            else
                off = OFFSET_W'($urandom);
            issue_entry(CMD_READ, $urandom, $urandom, off);
        end
    endtask

    initial begin
        logic [INTERVAL_W-1:0] iv;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_command       <= CMD_ADD;
        i_reading_value <= '0;
        i_now_seconds   <= '0;
        i_read_offset   <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty log, first record, zero elapsed, saturation, backwards
        write_interval(16'd1);
        issue_entry(CMD_READ, $urandom, $urandom, 8'd0);
        issue_entry(CMD_READ, $urandom, $urandom, 8'hFF);
        issue_entry(CMD_ADD, 32'h0000_0000, 32'd0, OFFSET_W'($urandom));
        issue_entry(CMD_ADD, 32'hFFFF_FFFF, 32'd0, OFFSET_W'($urandom));
        issue_entry(CMD_ADD, 32'h1234_5678, 32'd1, OFFSET_W'($urandom));
        issue_entry(CMD_ADD, 32'hA5A5_5A5A, 32'hFFFF_FFFF, OFFSET_W'($urandom));
        issue_entry(CMD_ADD, 32'h8000_0001, 32'd5, OFFSET_W'($urandom));
        for (int k = 0; k < 6; k++) issue_entry(CMD_READ, $urandom, $urandom, OFFSET_W'(k));
        issue_entry(CMD_READ, $urandom, $urandom, 8'hFF);

        // Directed: rounding around the half interval, zero and widest interval
        write_interval(16'd2);
        issue_entry(CMD_ADD, $urandom, 32'd6, OFFSET_W'($urandom));
        issue_entry(CMD_ADD, $urandom, 32'd6, OFFSET_W'($urandom));
        write_interval(16'd4);
        issue_entry(CMD_ADD, $urandom, 32'd7, OFFSET_W'($urandom));
        issue_entry(CMD_ADD, $urandom, 32'd9, OFFSET_W'($urandom));
        issue_entry(CMD_ADD, $urandom, 32'd14, OFFSET_W'($urandom));
        write_interval(16'd0);
        issue_entry(CMD_ADD, $urandom, 32'd17, OFFSET_W'($urandom));
        write_interval(16'hFFFF);
        issue_entry(CMD_ADD, $urandom, 32'd17 + 32'd32767, OFFSET_W'($urandom));
        issue_entry(CMD_ADD, $urandom, 32'd17 + 32'd32767 + 32'd32768, OFFSET_W'($urandom));
        issue_entry(CMD_READ, $urandom, $urandom, 8'd0);
        issue_entry(CMD_READ, $urandom, $urandom, 8'd12);
        issue_entry(CMD_READ, $urandom, $urandom, 8'd13);

        // Random phases, one interval setting each
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       iv = 16'd1;
                1:       iv = 16'd0;
                2:       iv = 16'hFFFF;
                3:       iv = 16'd2;
                4:       iv = 16'd60;
                5:       iv = 16'd7;
                7:       iv = 16'd3600;
                8:       iv = 16'd1;
                default: iv = INTERVAL_W'($urandom_range(1, 65535));
            endcase
            write_interval(iv);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // switch between back-to-back stretches and gapped ones
                if (n % 16 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
                issue_random();
            end
        end

        wait_log_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
